### hdl/tlrf_pkg.sv
// shared types, constants and helpers of the text line rule filter
package tlrf_pkg;

  localparam int MAX_RULES  = 16;
  localparam int RULE_W     = $clog2(MAX_RULES);
  localparam int NAME_BYTES = 63;
  localparam int NAME_W     = $clog2(NAME_BYTES + 1);
  localparam int ROW_W      = NAME_BYTES * 8;
  localparam int PID_W      = 23;
  localparam int ADDR_W     = 64;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 8;
  localparam logic [7:0] CHAR_DASH = 8'h2d;

  typedef enum logic [2:0] {
    ACT_LINE   = 3'd0,
    ACT_STAGE  = 3'd1,
    ACT_ADD    = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVERTED  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    KIND_VERDICT = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  // sequencer of the execution side
  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SCAN, S_REM, S_REM_DONE, S_EMIT
  } back_state_e;

  typedef struct packed {
    action_e            act;
    logic [7:0]         character;
    logic               last;
    logic [PID_W-1:0]   pid;
    logic [ADDR_W-1:0]  rng_lo;
    logic [ADDR_W-1:0]  rng_hi;
  } cmd_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

### hdl/tlrf_ram.sv
// generic single write port ram with registered read
module tlrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/tlrf_front.sv
// input side: accepts transfers, decodes the action and queues commands
module tlrf_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       in_action_i,
  input  logic [7:0]                       in_character_i,
  input  logic                             in_last_i,
  input  logic [tlrf_pkg::PID_W-1:0]       in_pid_i,
  input  logic [tlrf_pkg::ADDR_W-1:0]      in_rng_lo_i,
  input  logic [tlrf_pkg::ADDR_W-1:0]      in_rng_hi_i,
  input  logic                             pop_i,
  output tlrf_pkg::cmd_t                   cmd_o,
  output tlrf_pkg::queue_stat_t            stat_o
);

  tlrf_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           known;
  logic           push;
  tlrf_pkg::cmd_t cmd_in;

  always_comb begin
    known = 1'b0;
    unique case (in_action_i)
      tlrf_pkg::ACT_LINE, tlrf_pkg::ACT_STAGE, tlrf_pkg::ACT_ADD,
      tlrf_pkg::ACT_REMOVE, tlrf_pkg::ACT_CLEAR: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_ready_o = (count_q != 2'd2);
  // unknown actions are taken and dropped
  assign push       = in_valid_i && in_ready_o && known;

  assign cmd_in.act       = tlrf_pkg::action_e'(in_action_i);
  assign cmd_in.character = in_character_i;
  assign cmd_in.last      = in_last_i;
  assign cmd_in.pid       = in_pid_i;
  assign cmd_in.rng_lo    = in_rng_lo_i;
  assign cmd_in.rng_hi    = in_rng_hi_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.valid = (count_q != 2'd0);
  assign stat_o.full  = (count_q == 2'd2);

endmodule

### hdl/tlrf_back.sv
// execution side: rule table, line scan, commands and the result register
module tlrf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tlrf_pkg::cmd_t            cmd_i,
  input  tlrf_pkg::queue_stat_t     qstat_i,
  output logic                      pop_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic                      res_kind_o,
  output logic                      res_hide_o,
  output logic [1:0]                res_status_o
);

  localparam int NB = tlrf_pkg::NAME_BYTES;
  localparam int NR = tlrf_pkg::MAX_RULES;
  localparam int RW = tlrf_pkg::RULE_W;
  localparam int NW = tlrf_pkg::NAME_W;

  tlrf_pkg::back_state_e state_q, state_d;

  tlrf_pkg::cmd_t cmd_q;
  logic [RW-1:0]  cnt_q;

  logic [NR-1:0]                   valid_q, hit_q;
  logic [tlrf_pkg::ADDR_W-1:0]     start_q [NR];
  logic [tlrf_pkg::ADDR_W-1:0]     end_q   [NR];
  logic [tlrf_pkg::PID_W-1:0]      owner_q [NR];
  logic [NW-1:0]                   nlen_q  [NR];
  logic [RW-1:0]                   rank_q  [NR];

  // staged name kept newest byte first, so it lines up with the window
  logic [7:0]    stage_q [NB];
  logic [NW-1:0] stage_cnt_q, stage_nlen_q;
  logic          stage_term_q;

  logic [7:0]                  win_q [NB];
  logic [NW-1:0]               seen_q;
  logic [tlrf_pkg::ADDR_W-1:0] paddr_q;
  logic                        pact_q;

  logic          hide_q, found_q;
  logic [RW-1:0] best_q;
  logic [1:0]    status_q;
  logic          kind_q;

  logic       res_valid_q, res_kind_q, res_hide_q;
  logic [1:0] res_status_q;

  // name row memory
  logic                      ram_we;
  logic [RW-1:0]             ram_waddr, ram_raddr;
  logic [tlrf_pkg::ROW_W-1:0] ram_wdata, ram_rdata;

  tlrf_ram #(
    .WIDTH(tlrf_pkg::ROW_W),
    .DEPTH(NR)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // free slot search
  logic          any_free;
  logic [RW-1:0] free_slot;
  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int r = NR - 1; r >= 0; r--) begin
      if (!valid_q[r]) begin
        any_free  = 1'b1;
        free_slot = RW'(r);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      ram_wdata[k*8 +: 8] = stage_q[k];
    end
  end

  // name compare of the rule under scan against the window
  logic [NB-1:0] byte_ok;
  logic          name_match, owner_ok, range_hit, new_hit;
  logic [NW-1:0] cur_nlen;
  always_comb begin
    cur_nlen = nlen_q[cnt_q];
    for (int k = 0; k < NB; k++) begin
      byte_ok[k] = (win_q[k] == ram_rdata[k*8 +: 8]) || (NW'(k) >= cur_nlen);
    end
    name_match = valid_q[cnt_q] && (cur_nlen != '0) && (seen_q >= cur_nlen) && (&byte_ok);
    new_hit    = hit_q[cnt_q] || name_match;
    owner_ok   = (owner_q[cnt_q] == '0) || (owner_q[cnt_q] == cmd_q.pid);
    range_hit  = (start_q[cnt_q] != '0) && (paddr_q >= start_q[cnt_q]) &&
                 (paddr_q < end_q[cnt_q]);
  end

  logic rem_match;
  assign rem_match = valid_q[cnt_q] && (start_q[cnt_q] == cmd_q.rng_lo) &&
                     (owner_q[cnt_q] == cmd_q.pid) &&
                     (!found_q || rank_q[cnt_q] < rank_q[best_q]);

  logic inverted;
  assign inverted = (cmd_i.rng_lo != '0) && (cmd_i.rng_hi <= cmd_i.rng_lo);

  logic [4:0] hx;
  assign hx = tlrf_pkg::hex_digit(cmd_q.character);

  logic scan_end;
  assign scan_end = (cnt_q == RW'(NR - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlrf_pkg::S_IDLE: begin
        if (qstat_i.valid) begin
          unique case (cmd_i.act)
            tlrf_pkg::ACT_LINE:   state_d = tlrf_pkg::S_PREP;
            tlrf_pkg::ACT_REMOVE: state_d = tlrf_pkg::S_REM;
            tlrf_pkg::ACT_ADD,
            tlrf_pkg::ACT_CLEAR:  state_d = tlrf_pkg::S_EMIT;
            default:              state_d = tlrf_pkg::S_IDLE;
          endcase
        end
      end
      tlrf_pkg::S_PREP:     state_d = tlrf_pkg::S_SCAN;
      tlrf_pkg::S_SCAN: begin
        if (scan_end) state_d = cmd_q.last ? tlrf_pkg::S_EMIT : tlrf_pkg::S_IDLE;
      end
      tlrf_pkg::S_REM:      if (scan_end) state_d = tlrf_pkg::S_REM_DONE;
      tlrf_pkg::S_REM_DONE: state_d = tlrf_pkg::S_EMIT;
      tlrf_pkg::S_EMIT:     if (!res_valid_q) state_d = tlrf_pkg::S_IDLE;
      default:              state_d = tlrf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o     = (state_q == tlrf_pkg::S_IDLE) && qstat_i.valid;
    ram_we    = pop_o && (cmd_i.act == tlrf_pkg::ACT_ADD) && !inverted && any_free;
    ram_waddr = free_slot;
    ram_raddr = (state_q == tlrf_pkg::S_SCAN) ? cnt_q + RW'(1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tlrf_pkg::S_IDLE;
      valid_q      <= '0;
      hit_q        <= '0;
      stage_cnt_q  <= '0;
      stage_nlen_q <= '0;
      stage_term_q <= 1'b0;
      seen_q       <= '0;
      paddr_q      <= '0;
      pact_q       <= 1'b1;
      res_valid_q  <= 1'b0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      hide_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        tlrf_pkg::S_IDLE: begin
          cnt_q   <= '0;
          found_q <= 1'b0;
          hide_q  <= 1'b0;
          if (qstat_i.valid) begin
            cmd_q <= cmd_i;
            unique case (cmd_i.act)
              tlrf_pkg::ACT_STAGE: begin
                if (stage_cnt_q < NW'(NB)) begin
                  stage_cnt_q <= stage_cnt_q + NW'(1);
                  if (!stage_term_q) begin
                    if (cmd_i.character == 8'd0) begin
                      stage_term_q <= 1'b1;
                    end else begin
                      stage_q[0]   <= cmd_i.character;
                      for (int k = 1; k < NB; k++) stage_q[k] <= stage_q[k-1];
                      stage_nlen_q <= stage_nlen_q + NW'(1);
                    end
                  end
                end
              end
              tlrf_pkg::ACT_ADD: begin
                kind_q       <= tlrf_pkg::KIND_STATUS;
                stage_cnt_q  <= '0;
                stage_nlen_q <= '0;
                stage_term_q <= 1'b0;
                if (inverted) begin
                  status_q <= tlrf_pkg::ST_INVERTED;
                end else if (!any_free) begin
                  status_q <= tlrf_pkg::ST_FULL;
                end else begin
                  status_q <= tlrf_pkg::ST_OK;
                  for (int r = 0; r < NR; r++) begin
                    if (valid_q[r]) rank_q[r] <= rank_q[r] + RW'(1);
                  end
                  valid_q[free_slot] <= 1'b1;
                  hit_q[free_slot]   <= 1'b0;
                  start_q[free_slot] <= cmd_i.rng_lo;
                  end_q[free_slot]   <= cmd_i.rng_hi;
                  owner_q[free_slot] <= cmd_i.pid;
                  nlen_q[free_slot]  <= stage_nlen_q;
                  rank_q[free_slot]  <= '0;
                end
              end
              tlrf_pkg::ACT_CLEAR: begin
                kind_q   <= tlrf_pkg::KIND_STATUS;
                status_q <= tlrf_pkg::ST_OK;
                valid_q  <= '0;
                hit_q    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        tlrf_pkg::S_PREP: begin
          win_q[0] <= cmd_q.character;
          for (int k = 1; k < NB; k++) win_q[k] <= win_q[k-1];
          if (seen_q < NW'(NB)) seen_q <= seen_q + NW'(1);
          if (pact_q) begin
            if (cmd_q.character == tlrf_pkg::CHAR_DASH || !hx[4]) begin
              pact_q <= 1'b0;
            end else begin
              paddr_q <= {paddr_q[tlrf_pkg::ADDR_W-5:0], hx[3:0]};
            end
          end
        end
        tlrf_pkg::S_SCAN: begin
          cnt_q <= cnt_q + RW'(1);
          if (valid_q[cnt_q] && owner_ok && (new_hit || range_hit)) hide_q <= 1'b1;
          if (scan_end && cmd_q.last) begin
            hit_q    <= '0;
            seen_q   <= '0;
            paddr_q  <= '0;
            pact_q   <= 1'b1;
            kind_q   <= tlrf_pkg::KIND_VERDICT;
            status_q <= tlrf_pkg::ST_OK;
          end else begin
            hit_q[cnt_q] <= new_hit;
          end
        end
        tlrf_pkg::S_REM: begin
          cnt_q <= cnt_q + RW'(1);
          if (rem_match) begin
            found_q <= 1'b1;
            best_q  <= cnt_q;
          end
        end
        tlrf_pkg::S_REM_DONE: begin
          kind_q <= tlrf_pkg::KIND_STATUS;
          if (!found_q) begin
            status_q <= tlrf_pkg::ST_NOT_FOUND;
          end else begin
            status_q <= tlrf_pkg::ST_OK;
            for (int r = 0; r < NR; r++) begin
              if (valid_q[r] && rank_q[r] > rank_q[best_q]) rank_q[r] <= rank_q[r] - RW'(1);
            end
            valid_q[best_q] <= 1'b0;
            hit_q[best_q]   <= 1'b0;
          end
        end
        tlrf_pkg::S_EMIT: begin
          if (!res_valid_q) begin
            res_valid_q  <= 1'b1;
            res_kind_q   <= kind_q;
            res_hide_q   <= (kind_q == tlrf_pkg::KIND_VERDICT) && hide_q;
            res_status_q <= status_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_kind_o   = res_kind_q;
  assign res_hide_o   = res_hide_q;
  assign res_status_o = res_status_q;

endmodule

### hdl/text_line_rule_filter_unit.sv
// top level of the text line rule filter
//
// Input stream: tuser carries the action, tlast marks the last line byte,
// tdata carries the byte, the owner id and the range bounds. Output stream:
// tuser is the result kind (verdict or command status), tdata holds hide and
// status. Only last line bytes and add, remove and clear produce a result.
// Commands enter a two-entry queue, so the input side keeps taking transfers
// while the rule engine works or a result waits on the output.
// Per item in the engine: a line byte is popped, shifted into the window,
// then held against each of the 16 rule slots in turn through the name row
// memory; a last byte then loads the result. Stage is done at the pop, add
// and clear load their status after it, and remove scans the 16 slots for
// the newest match before it loads its status. Reset empties the table, the
// staged name and the line in progress; no clearing pass is needed. When the
// receiver stalls, the held result blocks the next result only; the queue
// fills and then tready drops.
module text_line_rule_filter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // character, pid, rng_lo, rng_hi, zero pad
  input  logic [tlrf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [2:0]                         s_axis_tuser,  // action
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tlrf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // hide, status, zero pad
  output logic                               m_axis_tuser   // kind
);

  tlrf_pkg::cmd_t        cmd;
  tlrf_pkg::queue_stat_t qstat;
  logic                  pop;
  logic                  res_hide;
  logic [1:0]            res_status;

  tlrf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_action_i    (s_axis_tuser),
    .in_character_i (s_axis_tdata[7:0]),
    .in_last_i      (s_axis_tlast),
    .in_pid_i       (s_axis_tdata[30:8]),
    .in_rng_lo_i    (s_axis_tdata[94:31]),
    .in_rng_hi_i    (s_axis_tdata[158:95]),
    .pop_i          (pop),
    .cmd_o          (cmd),
    .stat_o         (qstat)
  );

  tlrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_kind_o   (m_axis_tuser),
    .res_hide_o   (res_hide),
    .res_status_o (res_status)
  );

  assign m_axis_tdata = {5'd0, res_status, res_hide};

`ifndef NO_ASSERTIONS
  a_verdict_status_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tlrf_pkg::KIND_VERDICT) |->
      m_axis_tdata[2:1] == tlrf_pkg::ST_OK)
    else $error("line verdict carries a nonzero status");

  a_status_no_hide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tlrf_pkg::KIND_STATUS) |-> !m_axis_tdata[0])
    else $error("command status carries hide");

  a_ready_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> qstat.full && qstat.valid)
    else $error("input stalled while the queue has room");

  a_pop_needs_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qstat.valid)
    else $error("queue popped while empty");
`endif

endmodule
